/* sv/sfp_pkg.sv */
// Package for the sample FIFO with peek: payload structs, operation codes,
// register indexes and the controller/datapath command and status types.
// No dependencies.
`default_nettype none

package sfp_pkg;

  localparam int CNT_W    = 11;
  localparam int SAMPLE_W = 32;
  localparam int OP_W     = 3;

  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_DROP   = 3'd2;
  localparam logic [OP_W-1:0] OP_PEEK_H = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK_T = 3'd4;
  localparam logic [OP_W-1:0] OP_FILL   = 3'd5;
  localparam logic [OP_W-1:0] OP_REGAP  = 3'd6;

  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [SAMPLE_W-1:0] sample;
    logic [CNT_W-1:0]    amount;
    logic [CNT_W-1:0]    offset;
  } sfp_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] read_sample;
    logic [CNT_W-1:0]    done_count;
    logic                ok;
    logic [CNT_W-1:0]    occupancy;
  } sfp_out_t;

  typedef struct packed {
    logic accept;
    logic walk_step;
  } sfp_cmd_t;

  typedef struct packed {
    logic needs_walk;
    logic walk_last;
  } sfp_stat_t;

endpackage

`default_nettype wire

/* sv/sfp_ctrl.sv */
// Controller for the sample FIFO with peek: accepts items, steps the
// datapath through fill/regap walks and owns the result valid flag.
// Depends on sfp_pkg.
`default_nettype none

module sfp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sfp_pkg::sfp_stat_t stat,
  output sfp_pkg::sfp_cmd_t  cmd
);
  import sfp_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.accept    = 1'b0;
    cmd.walk_step = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          if (stat.needs_walk) begin
            state_nxt = ST_WALK;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_last) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/sfp_datapath.sv */
// Datapath for the sample FIFO with peek: ring memory, head/fill/capacity
// registers, walk address counter and result registers.
// Depends on sfp_pkg; driven by sfp_ctrl commands.
`default_nettype none

module sfp_datapath #(
  parameter int DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sfp_pkg::sfp_in_t           in_data,
  input  sfp_pkg::sfp_cmd_t          cmd,
  output sfp_pkg::sfp_stat_t         stat,
  input  logic                       cap_we,
  input  logic [sfp_pkg::CNT_W-1:0]  cap_wdata,
  output logic [sfp_pkg::CNT_W-1:0]  cap_q,
  output sfp_pkg::sfp_out_t          out_data
);
  import sfp_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int PW = ((AW > CNT_W) ? AW : CNT_W) + 1;
  localparam logic [CNT_W-1:0] CAP_RST = (DEPTH < 1024) ? CNT_W'(DEPTH) : CNT_W'(1024);
  localparam logic [PW-1:0]    DEPTH_P = PW'(DEPTH);
  localparam logic [AW-1:0]    LAST_IDX = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] wrap_idx(input logic [PW-1:0] s);
    logic [PW-1:0] t;
    t = (s >= DEPTH_P) ? s - DEPTH_P : s;
    return t[AW-1:0];
  endfunction

  logic [SAMPLE_W-1:0] mem [DEPTH];

  logic [CNT_W-1:0]    cap_r;
  logic [AW-1:0]       head_r, head_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [AW-1:0]       walk_addr_r, walk_addr_nxt;
  logic [CNT_W-1:0]    walk_cnt_r, walk_cnt_nxt;
  logic [SAMPLE_W-1:0] walk_data_r, walk_data_nxt;
  logic [CNT_W-1:0]    done_r, done_nxt;
  logic                ok_r, ok_nxt;
  logic [CNT_W-1:0]    occ_r;
  logic                rd_sel_r, rd_sel_nxt;
  logic [SAMPLE_W-1:0] rd_q_r;
  logic [CNT_W-1:0]    cap_clamp;

  logic                push_ok, pop_ok, peekh_ok, peekt_ok, regap_ok, grow;
  logic [CNT_W-1:0]    drop_n, grow_n, shrink_n, adv_rel, addr_rel;
  logic [AW-1:0]       adv_head, back_head, acc_addr;
  logic                acc_we, acc_re, needs_walk;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [SAMPLE_W-1:0] mem_wdata;

  assign cap_clamp = (cap_wdata == '0) ? CNT_W'(1) :
                     (PW'(cap_wdata) > DEPTH_P) ? CNT_W'(DEPTH) : cap_wdata;

  assign push_ok  = fill_r < cap_r;
  assign pop_ok   = fill_r != '0;
  assign peekh_ok = in_data.offset < fill_r;
  assign peekt_ok = (in_data.offset != '0) && (in_data.offset <= fill_r);
  assign regap_ok = in_data.amount <= cap_r;
  assign grow     = in_data.amount > fill_r;
  assign drop_n   = (in_data.amount < fill_r) ? in_data.amount : fill_r;
  assign grow_n   = in_data.amount - fill_r;
  assign shrink_n = fill_r - in_data.amount;

  assign adv_head  = wrap_idx(PW'(head_r) + PW'(adv_rel));
  assign acc_addr  = wrap_idx(PW'(head_r) + PW'(addr_rel));
  assign back_head = wrap_idx(PW'(head_r) + DEPTH_P - PW'(grow_n));

  always_comb begin
    adv_rel    = '0;
    addr_rel   = '0;
    head_nxt   = head_r;
    fill_nxt   = fill_r;
    done_nxt   = '0;
    ok_nxt     = 1'b0;
    rd_sel_nxt = 1'b0;
    acc_we     = 1'b0;
    acc_re     = 1'b0;
    needs_walk = 1'b0;
    unique case (in_data.operation)
      OP_PUSH: begin
        addr_rel = fill_r;
        if (push_ok) begin
          acc_we   = 1'b1;
          fill_nxt = fill_r + 1'b1;
          done_nxt = CNT_W'(1);
          ok_nxt   = 1'b1;
        end
      end
      OP_POP: begin
        adv_rel = CNT_W'(1);
        if (pop_ok) begin
          acc_re     = 1'b1;
          rd_sel_nxt = 1'b1;
          head_nxt   = adv_head;
          fill_nxt   = fill_r - 1'b1;
          done_nxt   = CNT_W'(1);
          ok_nxt     = 1'b1;
        end
      end
      OP_DROP: begin
        adv_rel  = drop_n;
        head_nxt = adv_head;
        fill_nxt = fill_r - drop_n;
        done_nxt = drop_n;
        ok_nxt   = 1'b1;
      end
      OP_PEEK_H: begin
        addr_rel = in_data.offset;
        if (peekh_ok) begin
          acc_re     = 1'b1;
          rd_sel_nxt = 1'b1;
          ok_nxt     = 1'b1;
        end
      end
      OP_PEEK_T: begin
        addr_rel = fill_r - in_data.offset;
        if (peekt_ok) begin
          acc_re     = 1'b1;
          rd_sel_nxt = 1'b1;
          ok_nxt     = 1'b1;
        end
      end
      OP_FILL: begin
        ok_nxt     = 1'b1;
        needs_walk = pop_ok;
      end
      OP_REGAP: begin
        adv_rel = shrink_n;
        if (regap_ok) begin
          ok_nxt   = 1'b1;
          fill_nxt = in_data.amount;
          if (grow) begin
            head_nxt   = back_head;
            needs_walk = 1'b1;
          end else begin
            head_nxt = adv_head;
            done_nxt = shrink_n;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (in_data.operation == OP_FILL) begin
      walk_addr_nxt = head_r;
      walk_cnt_nxt  = fill_r;
      walk_data_nxt = in_data.sample;
    end else begin
      walk_addr_nxt = back_head;
      walk_cnt_nxt  = grow_n;
      walk_data_nxt = '0;
    end
  end

  assign stat.needs_walk = needs_walk;
  assign stat.walk_last  = walk_cnt_r == CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r      <= CAP_RST;
      head_r     <= '0;
      fill_r     <= '0;
      walk_cnt_r <= '0;
    end else if (cap_we) begin
      cap_r  <= cap_clamp;
      head_r <= '0;
      fill_r <= '0;
    end else if (cmd.accept) begin
      head_r     <= head_nxt;
      fill_r     <= fill_nxt;
      walk_cnt_r <= walk_cnt_nxt;
    end else if (cmd.walk_step) begin
      walk_cnt_r <= walk_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      done_r      <= done_nxt;
      ok_r        <= ok_nxt;
      occ_r       <= fill_nxt;
      rd_sel_r    <= rd_sel_nxt;
      walk_addr_r <= walk_addr_nxt;
      walk_data_r <= walk_data_nxt;
    end else if (cmd.walk_step) begin
      walk_addr_r <= (walk_addr_r == LAST_IDX) ? '0 : walk_addr_r + 1'b1;
    end
  end

  assign mem_we    = (cmd.accept && acc_we) || cmd.walk_step;
  assign mem_waddr = cmd.walk_step ? walk_addr_r : acc_addr;
  assign mem_wdata = cmd.walk_step ? walk_data_r : in_data.sample;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.accept && acc_re) begin
      rd_q_r <= mem[(in_data.operation == OP_POP) ? head_r : acc_addr];
    end
  end

  assign cap_q                = cap_r;
  assign out_data.read_sample = rd_sel_r ? rd_q_r : '0;
  assign out_data.done_count  = done_r;
  assign out_data.ok          = ok_r;
  assign out_data.occupancy   = occ_r;

endmodule

`default_nettype wire

/* sv/sample_fifo_with_peek_top.sv */
// Sample FIFO with peek, top level: APB-style capacity register, controller
// and datapath. Depends on sfp_pkg, sfp_ctrl and sfp_datapath.
// Push, pop, drop, peek and a shrinking regap give their result in the
// cycle after the transfer; a non-empty fill and a growing regap first
// rewrite their entries, one per cycle through the single memory write port.
// Throughput: one item per cycle when no walk runs and results are taken.
// Reset (rst_n low, synchronous): queue empty, head at 0, capacity min(1024,
// DEPTH); memory contents are kept, never cleared.
`default_nettype none

module sample_fifo_with_peek_top #(
  parameter int DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sfp_pkg::sfp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sfp_pkg::sfp_out_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import sfp_pkg::*;

  sfp_cmd_t         cmd;
  sfp_stat_t        stat;
  logic             cap_we;
  logic [CNT_W-1:0] cap_q;

  assign pready = 1'b1;
  assign cap_we = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CNT_W){1'b0}}, cap_q} : '0;

  sfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sfp_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .cap_we    (cap_we),
    .cap_wdata (pwdata[CNT_W-1:0]),
    .cap_q     (cap_q),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* verif/tb_sample_fifo_with_peek_top.sv */
// Testbench for sample_fifo_with_peek_top: directed and random queue operations, with
// capacity rewrites between phases and a shadow queue that predicts every result.
// Depends on sfp_pkg and the sample_fifo_with_peek_top RTL.
`default_nettype none

module tb_sample_fifo_with_peek_top;
  import sfp_pkg::*;

  localparam int RING_DEPTH = 1024;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int DRAIN_CYCLES = 32;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam logic [OP_W-1:0] OP_RESERVED = 3'd7;

  class fifo_shadow;
    bit [SAMPLE_W-1:0] ring [RING_DEPTH];
    bit [9:0] head;
    int unsigned level;
    int unsigned cap;
    sfp_out_t pending_replies [$];
    int mismatches;

    function new();
      head = 0;
      level = 0;
      cap = RING_DEPTH;
      mismatches = 0;
    endfunction

    function bit [9:0] slot(int unsigned rel);
      return 10'(head + rel);
    endfunction

    function void set_capacity(logic [31:0] value);
      int unsigned v;
      v = value[CNT_W-1:0];
      if (v == 0) v = 1;
      if (v > RING_DEPTH) v = RING_DEPTH;
      cap = v;
      head = 0;
      level = 0;
    endfunction

    function void note_operation(sfp_in_t op);
      sfp_out_t res;
      int unsigned n;
      res = '0;
      case (op.operation)
        OP_PUSH: begin
          if (level < cap) begin
            ring[slot(level)] = op.sample;
            level++;
            res.done_count = 11'd1;
            res.ok = 1'b1;
          end
        end
        OP_POP: begin
          if (level > 0) begin
            res.read_sample = ring[slot(0)];
            head = slot(1);
            level--;
            res.done_count = 11'd1;
            res.ok = 1'b1;
          end
        end
        OP_DROP: begin
          n = (op.amount < level) ? op.amount : level;
          head = slot(n);
          level -= n;
          res.done_count = 11'(n);
          res.ok = 1'b1;
        end
        OP_PEEK_H: begin
          if (op.offset < level) begin
            res.read_sample = ring[slot(op.offset)];
            res.ok = 1'b1;
          end
        end
        OP_PEEK_T: begin
          if (op.offset >= 1 && op.offset <= level) begin
            res.read_sample = ring[slot(level - op.offset)];
            res.ok = 1'b1;
          end
        end
        OP_FILL: begin
          for (int unsigned i = 0; i < level; i++) ring[slot(i)] = op.sample;
          res.ok = 1'b1;
        end
        OP_REGAP: begin
          if (op.amount <= cap) begin
            if (op.amount > level) begin
              n = op.amount - level;
              head = 10'(head - n);
              for (int unsigned i = 0; i < n; i++) ring[slot(i)] = '0;
            end else begin
              n = level - op.amount;
              head = slot(n);
              res.done_count = 11'(n);
            end
            level = op.amount;
            res.ok = 1'b1;
          end
        end
        default: begin
        end
      endcase
      res.occupancy = 11'(level);
      pending_replies.push_back(res);
    endfunction

    function void check_result(sfp_out_t got);
      sfp_out_t exp;
      if (pending_replies.size() == 0) begin
        $error("result with no operation outstanding: %h", got);
        mismatches++;
        return;
      end
      exp = pending_replies.pop_front();
      if (got.read_sample !== exp.read_sample) begin
        $error("read_sample expected %h got %h", exp.read_sample, got.read_sample);
        mismatches++;
      end
      if (got.done_count !== exp.done_count) begin
        $error("done_count expected %0d got %0d", exp.done_count, got.done_count);
        mismatches++;
      end
      if (got.ok !== exp.ok) begin
        $error("ok expected %b got %b", exp.ok, got.ok);
        mismatches++;
      end
      if (got.occupancy !== exp.occupancy) begin
        $error("occupancy expected %0d got %0d", exp.occupancy, got.occupancy);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return pending_replies.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  sfp_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  sfp_out_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  fifo_shadow shadow;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  sample_fifo_with_peek_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) shadow.note_operation(in_data);
    if (rst_n && out_valid && out_ready) shadow.check_result(out_data);
  end

  task automatic send_item(input sfp_in_t item);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold the input idle until every outstanding result has come back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(4 * REG_CAPACITY);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    shadow.set_capacity(value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic sfp_in_t make_item(logic [OP_W-1:0] op, logic [31:0] smp,
                                        int unsigned amt, int unsigned ofs);
    sfp_in_t it;
    it.operation = op;
    it.sample = smp;
    it.amount = 11'(amt);
    it.offset = 11'(ofs);
    return it;
  endfunction

  // mostly well-formed operations sized to the current occupancy, some raw noise
  function automatic sfp_in_t random_item();
    sfp_in_t it;
    int unsigned pick;
    int unsigned lvl;
    int unsigned top;
    lvl = shadow.level;
    top = (lvl + 8 < shadow.cap) ? lvl + 8 : shadow.cap;
    it.operation = OP_PUSH;
    it.sample = $urandom;
    it.amount = 11'($urandom);
    it.offset = 11'($urandom);
    pick = $urandom_range(99);
    if (pick < 36) begin
      it.operation = OP_PUSH;
    end else if (pick < 52) begin
      it.operation = OP_POP;
    end else if (pick < 59) begin
      it.operation = OP_DROP;
      if ($urandom_range(9) != 0) it.amount = 11'($urandom_range(0, 6));
    end else if (pick < 69) begin
      it.operation = OP_PEEK_H;
      if ($urandom_range(9) != 0) it.offset = 11'($urandom_range(0, lvl + 1));
    end else if (pick < 79) begin
      it.operation = OP_PEEK_T;
      if ($urandom_range(9) != 0) it.offset = 11'($urandom_range(0, lvl + 1));
    end else if (pick < 84) begin
      it.operation = OP_FILL;
    end else if (pick < 97) begin
      it.operation = OP_REGAP;
      case ($urandom_range(19))
        0: it.amount = 11'($urandom);
        1: it.amount = 11'(shadow.cap);
        2: it.amount = 11'(shadow.cap + 1);
        default: it.amount = 11'($urandom_range(0, top));
      endcase
    end else begin
      it.operation = OP_RESERVED;
    end
    return it;
  endfunction

  initial begin
    sfp_in_t directed [$];
    int unsigned caps [PHASES];
    shadow = new();
    caps = '{2047, 1, 16, 0, 1024, 3, 0, 40};
    caps[6] = $urandom_range(2, 64);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_capacity(4);
    directed.push_back(make_item(OP_POP, 32'h0, 0, 0));
    directed.push_back(make_item(OP_PEEK_H, 32'h0, 0, 0));
    directed.push_back(make_item(OP_PEEK_T, 32'h0, 0, 1));
    directed.push_back(make_item(OP_FILL, 32'h1234_5678, 0, 0));
    directed.push_back(make_item(OP_DROP, 32'h0, 5, 0));
    directed.push_back(make_item(OP_PUSH, 32'h0000_0000, 0, 0));
    directed.push_back(make_item(OP_PUSH, 32'hFFFF_FFFF, 2047, 2047));
    directed.push_back(make_item(OP_PUSH, 32'hA5A5_A5A5, 0, 0));
    directed.push_back(make_item(OP_PUSH, 32'h5A5A_5A5A, 0, 0));
    directed.push_back(make_item(OP_PUSH, 32'h0000_0001, 0, 0));
    directed.push_back(make_item(OP_PEEK_H, 32'h0, 0, 0));
    directed.push_back(make_item(OP_PEEK_H, 32'h0, 0, 3));
    directed.push_back(make_item(OP_PEEK_H, 32'h0, 0, 4));
    directed.push_back(make_item(OP_PEEK_T, 32'h0, 0, 0));
    directed.push_back(make_item(OP_PEEK_T, 32'h0, 0, 1));
    directed.push_back(make_item(OP_PEEK_T, 32'h0, 0, 4));
    directed.push_back(make_item(OP_PEEK_T, 32'h0, 0, 2047));
    directed.push_back(make_item(OP_FILL, 32'hDEAD_BEEF, 0, 0));
    directed.push_back(make_item(OP_REGAP, 32'h0, 2047, 0));
    directed.push_back(make_item(OP_REGAP, 32'h0, 5, 0));
    directed.push_back(make_item(OP_REGAP, 32'h0, 2, 0));
    directed.push_back(make_item(OP_REGAP, 32'h0, 4, 0));
    directed.push_back(make_item(OP_POP, 32'h0, 0, 0));
    directed.push_back(make_item(OP_DROP, 32'h0, 2047, 0));
    directed.push_back(make_item(OP_RESERVED, 32'hFFFF_FFFF, 2047, 2047));
    foreach (directed[i]) send_item(directed[i]);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 45; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 45; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      write_capacity(caps[p]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // block the result side so the queue backs up into the input
        if (p == 4 && i == 10) hold_left = HOLD_OFF_CYCLES;
        if (p == 5 && i == ITEMS_PER_PHASE / 2) settle();
        send_item(random_item());
      end
      settle();
    end

    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #32000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
